FILE: hdl/ethernet_ipv4_l4_header_parser_unit_assert.svh
// Assertion macros for the header parser.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ETHERNET_IPV4_L4_HEADER_PARSER_UNIT_ASSERT_SVH
`define ETHERNET_IPV4_L4_HEADER_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define EIL4HP_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("same-cycle check failed");
`define EIL4HP_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define EIL4HP_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define EIL4HP_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

FILE: hdl/eil4hp_pkg.sv
package eil4hp_pkg;

    // Frame byte counter width
    localparam int COUNT_W = 12;

    // Header layout
    localparam logic [COUNT_W-1:0] IDX_ETHER_HI  = 12'd12;
    localparam logic [COUNT_W-1:0] IDX_ETHER_LO  = 12'd13;
    localparam logic [COUNT_W-1:0] IDX_IHL       = 12'd14;
    localparam logic [COUNT_W-1:0] IDX_PROTO     = 12'd23;
    localparam logic [COUNT_W-1:0] IDX_SRC_FIRST = 12'd26;
    localparam logic [COUNT_W-1:0] IDX_SRC_LAST  = 12'd29;

    // Offsets inside the L4 header
    localparam logic [COUNT_W-1:0] L4_SPORT_HI   = 12'd0;
    localparam logic [COUNT_W-1:0] L4_SPORT_LO   = 12'd1;
    localparam logic [COUNT_W-1:0] L4_DPORT_HI   = 12'd2;
    localparam logic [COUNT_W-1:0] L4_DPORT_LO   = 12'd3;
    localparam logic [COUNT_W-1:0] L4_TCP_DOFF   = 12'd12;

    localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
    localparam logic [7:0]  UDP_HDR_BYTES  = 8'd8;
    localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
    localparam logic [COUNT_W-1:0] TCP_MIN_FRAME = 12'd54;
    localparam logic [COUNT_W-1:0] UDP_MIN_FRAME = 12'd42;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    typedef enum logic [2:0] {
        ST_TCP_OK      = 3'd0,
        ST_UDP_OK      = 3'd1,
        ST_TOO_SHORT   = 3'd2,
        ST_NOT_IPV4    = 3'd3,
        ST_BAD_IHL     = 3'd4,
        ST_OTHER_PROTO = 3'd5,
        ST_BAD_L4      = 3'd6,
        ST_OVERSIZE    = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  payload_offset;
        logic [11:0] payload_length;
    } t_out_word;

    // Header fields that decide the verdict
    typedef struct packed {
        logic [15:0] ether_kind;
        logic [5:0]  ip_header_bytes;
        logic [7:0]  proto_number;
        logic [5:0]  tcp_header_bytes;
    } t_hdr_fields;

endpackage

FILE: hdl/eil4hp_stream_if.sv
interface eil4hp_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/ethernet_ipv4_l4_header_parser_unit.sv
// Ethernet/IPv4/TCP-UDP header parser. Frame bytes arrive one word per cycle on i_in,
// with last_byte set on the final byte; each frame yields exactly one result word on
// o_out, carrying a status (TCP ok, UDP ok or a reject reason), the source address,
// the L4 ports and the payload offset and length; for a rejected frame every field
// but status is zero. The block takes one byte every cycle but for the stall below: a
// byte passes an input register, then the capture and verdict logic, and a frame's
// result is loaded into the output register as its last byte leaves the input
// register, and held there until o_out takes it. The only stall is a last byte
// that finds the output register still holding a result that o_out has not taken.
// Frames longer than MAX_FRAME_BYTES stop the byte counter and are rejected as
// oversize; bytes without a final mark give no result.
`include "ethernet_ipv4_l4_header_parser_unit_assert.svh"

module ethernet_ipv4_l4_header_parser_unit #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    eil4hp_stream_if.sink   i_in,
    eil4hp_stream_if.source o_out
);

    localparam int CW = eil4hp_pkg::COUNT_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAME_BYTES);

    // Input register
    logic                  r_in_valid;
    eil4hp_pkg::t_in_word  r_in;

    // Frame state
    logic [CW-1:0]         r_byte_count,     n_byte_count;
    logic [15:0]           r_ether_kind,     n_ether_kind;
    logic [5:0]            r_ip_header_bytes, n_ip_header_bytes;
    logic [7:0]            r_proto_number,   n_proto_number;
    logic [31:0]           r_src_addr,       n_src_addr;
    logic [15:0]           r_src_port,       n_src_port;
    logic [15:0]           r_dst_port,       n_dst_port;
    logic [5:0]            r_tcp_header_bytes, n_tcp_header_bytes;

    // Output register
    logic                  r_out_valid;
    eil4hp_pkg::t_out_word r_out,            n_out;

    logic                     w_adv;
    logic                     w_fire;
    logic                     w_over;
    logic [CW-1:0]            w_len;
    logic [CW-1:0]            w_l4;
    logic [7:0]               w_b;
    eil4hp_pkg::t_hdr_fields  w_fields;
    eil4hp_pkg::t_status      w_status;
    logic [7:0]               w_hdr_bytes;
    logic                     w_out_reject;
    logic                     w_out_zeroed;

    // A non-final byte never needs the output register
    assign w_adv  = !r_in.last_byte || !r_out_valid || o_out.ready;
    assign w_fire = r_in_valid && w_adv;

    assign i_in.ready    = !r_in_valid || w_adv;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign w_b    = r_in.data_byte;
    assign w_over = r_byte_count >= MAX_COUNT;
    assign w_len  = r_byte_count + CW'(1);
    assign w_l4   = CW'(eil4hp_pkg::ETH_HDR_BYTES) + CW'(r_ip_header_bytes);

    // Capture header fields at their byte positions
    always_comb begin
        n_byte_count       = r_byte_count;
        n_ether_kind       = r_ether_kind;
        n_ip_header_bytes  = r_ip_header_bytes;
        n_proto_number     = r_proto_number;
        n_src_addr         = r_src_addr;
        n_src_port         = r_src_port;
        n_dst_port         = r_dst_port;
        n_tcp_header_bytes = r_tcp_header_bytes;
        if (!w_over) begin
            n_byte_count = w_len;
            if (r_byte_count == eil4hp_pkg::IDX_ETHER_HI) n_ether_kind[15:8] = w_b;
            if (r_byte_count == eil4hp_pkg::IDX_ETHER_LO) n_ether_kind[7:0]  = w_b;
            if (r_byte_count == eil4hp_pkg::IDX_IHL)      n_ip_header_bytes  = {w_b[3:0], 2'b00};
            if (r_byte_count == eil4hp_pkg::IDX_PROTO)    n_proto_number     = w_b;
            if (r_byte_count >= eil4hp_pkg::IDX_SRC_FIRST
                && r_byte_count <= eil4hp_pkg::IDX_SRC_LAST) begin
                n_src_addr = {r_src_addr[23:0], w_b};
            end
            // L4 fields only once a valid IHL is known
            if (r_byte_count > eil4hp_pkg::IDX_IHL
                && r_ip_header_bytes >= eil4hp_pkg::MIN_HDR_BYTES) begin
                if (r_byte_count == w_l4 + eil4hp_pkg::L4_SPORT_HI) n_src_port[15:8] = w_b;
                if (r_byte_count == w_l4 + eil4hp_pkg::L4_SPORT_LO) n_src_port[7:0]  = w_b;
                if (r_byte_count == w_l4 + eil4hp_pkg::L4_DPORT_HI) n_dst_port[15:8] = w_b;
                if (r_byte_count == w_l4 + eil4hp_pkg::L4_DPORT_LO) n_dst_port[7:0]  = w_b;
                if (r_byte_count == w_l4 + eil4hp_pkg::L4_TCP_DOFF) begin
                    n_tcp_header_bytes = {w_b[7:4], 2'b00};
                end
            end
        end
    end

    assign w_fields = '{ether_kind:       n_ether_kind,
                        ip_header_bytes:  n_ip_header_bytes,
                        proto_number:     n_proto_number,
                        tcp_header_bytes: n_tcp_header_bytes};

    eil4hp_verdict u_verdict (
        .i_fields    (w_fields),
        .i_len       (w_len),
        .i_over      (w_over),
        .o_status    (w_status),
        .o_hdr_bytes (w_hdr_bytes)
    );

    // Build the result word; zero all fields of a rejected frame
    always_comb begin
        n_out        = '0;
        n_out.status = w_status;
        if (w_status == eil4hp_pkg::ST_TCP_OK || w_status == eil4hp_pkg::ST_UDP_OK) begin
            n_out.source_address = n_src_addr;
            n_out.source_port    = n_src_port;
            n_out.dest_port      = n_dst_port;
            n_out.payload_offset = w_hdr_bytes;
            n_out.payload_length = w_len - CW'(w_hdr_bytes);
        end
    end

    // Take a new input word whenever the input register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.payload;
        end
    end

    // Advance frame state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in.last_byte)) begin
            r_byte_count       <= '0;
            r_ether_kind       <= '0;
            r_ip_header_bytes  <= '0;
            r_proto_number     <= '0;
            r_src_addr         <= '0;
            r_src_port         <= '0;
            r_dst_port         <= '0;
            r_tcp_header_bytes <= '0;
        end else if (w_fire) begin
            r_byte_count       <= n_byte_count;
            r_ether_kind       <= n_ether_kind;
            r_ip_header_bytes  <= n_ip_header_bytes;
            r_proto_number     <= n_proto_number;
            r_src_addr         <= n_src_addr;
            r_src_port         <= n_src_port;
            r_dst_port         <= n_dst_port;
            r_tcp_header_bytes <= n_tcp_header_bytes;
        end
    end

    // Load the result on the final byte; hold it until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    // Flag a held reject and whether its data fields are clear
    assign w_out_reject = r_out_valid
                          && r_out.status != eil4hp_pkg::ST_TCP_OK
                          && r_out.status != eil4hp_pkg::ST_UDP_OK;
    assign w_out_zeroed = r_out.source_address == 32'd0
                          && r_out.source_port == 16'd0
                          && r_out.dest_port == 16'd0
                          && r_out.payload_offset == 8'd0
                          && r_out.payload_length == 12'd0;

    `EIL4HP_ASSERT_SAME(a_count_saturates, i_clk, i_rst_n, 1'b1, r_byte_count <= MAX_COUNT)
    `EIL4HP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_fire && r_in.last_byte, r_out_valid)
    `EIL4HP_ASSERT_SAME(a_reject_zeroes, i_clk, i_rst_n, w_out_reject, w_out_zeroed)

endmodule

FILE: hdl/eil4hp_verdict.sv
module eil4hp_verdict (
    input  eil4hp_pkg::t_hdr_fields          i_fields,
    input  logic [eil4hp_pkg::COUNT_W-1:0]   i_len,
    input  logic                             i_over,
    output eil4hp_pkg::t_status              o_status,
    output logic [7:0]                       o_hdr_bytes
);

    logic [7:0] w_ip_end;
    logic [7:0] w_tcp_total;
    logic [7:0] w_udp_total;

    assign w_ip_end    = eil4hp_pkg::ETH_HDR_BYTES + {2'b00, i_fields.ip_header_bytes};
    assign w_tcp_total = w_ip_end + {2'b00, i_fields.tcp_header_bytes};
    assign w_udp_total = w_ip_end + eil4hp_pkg::UDP_HDR_BYTES;

    // Apply the checks in order; the first failure sets the status
    always_comb begin
        o_hdr_bytes = 8'd0;
        priority if (i_over) begin
            o_status = eil4hp_pkg::ST_OVERSIZE;
        end else if (i_len < eil4hp_pkg::UDP_MIN_FRAME) begin
            o_status = eil4hp_pkg::ST_TOO_SHORT;
        end else if (i_fields.ether_kind != eil4hp_pkg::ETHERTYPE_IPV4) begin
            o_status = eil4hp_pkg::ST_NOT_IPV4;
        end else if (i_fields.ip_header_bytes < eil4hp_pkg::MIN_HDR_BYTES
                     || {4'd0, w_ip_end} > i_len) begin
            o_status = eil4hp_pkg::ST_BAD_IHL;
        end else if (i_fields.proto_number == eil4hp_pkg::PROTO_TCP) begin
            o_hdr_bytes = w_tcp_total;
            priority if (i_len < eil4hp_pkg::TCP_MIN_FRAME) begin
                o_status = eil4hp_pkg::ST_TOO_SHORT;
            end else if (i_fields.tcp_header_bytes < eil4hp_pkg::MIN_HDR_BYTES
                         || {4'd0, w_tcp_total} > i_len) begin
                o_status = eil4hp_pkg::ST_BAD_L4;
            end else begin
                o_status = eil4hp_pkg::ST_TCP_OK;
            end
        end else if (i_fields.proto_number == eil4hp_pkg::PROTO_UDP) begin
            o_hdr_bytes = w_udp_total;
            if ({4'd0, w_udp_total} > i_len) begin
                o_status = eil4hp_pkg::ST_BAD_L4;
            end else begin
                o_status = eil4hp_pkg::ST_UDP_OK;
            end
        end else begin
            o_status = eil4hp_pkg::ST_OTHER_PROTO;
        end
    end

endmodule
